// ===== design/tspg_pkg.sv =====
// ----------------------------------------------------------------------------
// tspg_pkg
// Shared types and constants of the three-axis step pulse generator.
// ----------------------------------------------------------------------------
package tspg_pkg;

  localparam int NUM_AXES    = 3;
  localparam int POS_WIDTH   = 32;
  localparam int COUNT_WIDTH = 16;
  localparam int PHASE_WIDTH = 8;
  localparam int CFG_WIDTH   = 8;
  localparam int IDX_WIDTH   = 2;

  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_FREE_RUN = 2'd1,
    OP_LOAD     = 2'd2
  } op_t;

  // configuration register indexes
  localparam logic [IDX_WIDTH-1:0] REG_MOTOR_ENABLE = 2'd0;
  localparam logic [IDX_WIDTH-1:0] REG_PULSE_HIGH   = 2'd1;
  localparam logic [IDX_WIDTH-1:0] REG_STEP_PERIOD  = 2'd2;

  localparam logic [NUM_AXES-1:0]    MOTOR_ENABLE_RST = '0;
  localparam logic [PHASE_WIDTH-1:0] PULSE_HIGH_RST   = 8'd5;
  localparam logic [PHASE_WIDTH-1:0] STEP_PERIOD_RST  = 8'd10;

  localparam logic [1:0] LIMITS_CLOSED = 2'b11;

endpackage

// ===== design/three_axis_step_pulse_generator.sv =====
// ----------------------------------------------------------------------------
// three_axis_step_pulse_generator
// Step pulse timing, step counting and position tracking for x, y and z.
// ----------------------------------------------------------------------------
// Each item (tick or command) is taken at its accepting edge: the phase, step
// count, free-run and position registers of all three axes are updated by a
// single pass of compare and add logic at that edge, and the held result
// (pins, positions, busy) is presented the next cycle. One item per clock is
// sustained while the result side takes every result; the input stalls only
// while a result waits on out_ready. Configuration is written with cfg_we
// and takes effect for the next item.
module three_axis_step_pulse_generator (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      cfg_we,
  input  logic [tspg_pkg::IDX_WIDTH-1:0]            cfg_index,
  input  logic [tspg_pkg::CFG_WIDTH-1:0]            cfg_wdata,
  input  logic                                      in_valid,
  output logic                                      in_ready,
  input  logic [1:0]                                in_op,
  input  logic [1:0]                                in_axis,
  input  logic                                      in_run_enable,
  input  logic [tspg_pkg::COUNT_WIDTH-1:0]          in_step_count,
  input  logic [1:0]                                in_limits_x,
  input  logic [1:0]                                in_limits_y,
  input  logic [1:0]                                in_limits_z,
  input  logic [tspg_pkg::NUM_AXES-1:0]             in_dir_bits,
  output logic                                      out_valid,
  input  logic                                      out_ready,
  output logic [tspg_pkg::NUM_AXES-1:0]             out_step_pins,
  output logic signed [tspg_pkg::POS_WIDTH-1:0]     out_pos_x,
  output logic signed [tspg_pkg::POS_WIDTH-1:0]     out_pos_y,
  output logic signed [tspg_pkg::POS_WIDTH-1:0]     out_pos_z,
  output logic [tspg_pkg::NUM_AXES-1:0]             out_busy_mask
);

  localparam int NA = tspg_pkg::NUM_AXES;
  localparam int PW = tspg_pkg::PHASE_WIDTH;
  localparam int CW = tspg_pkg::COUNT_WIDTH;
  localparam int XW = tspg_pkg::POS_WIDTH;

  logic [NA-1:0]  motor_en_r;
  logic [PW-1:0]  pulse_high_r;
  logic [PW-1:0]  step_period_r;

  logic [PW-1:0]  phase_r    [NA];
  logic [PW-1:0]  phase_nxt  [NA];
  logic [CW-1:0]  steps_r    [NA];
  logic [CW-1:0]  steps_nxt  [NA];
  logic [XW-1:0]  pos_r      [NA];
  logic [XW-1:0]  pos_nxt    [NA];
  logic [NA-1:0]  free_run_r;
  logic [NA-1:0]  free_run_nxt;
  logic [NA-1:0]  pins_r;
  logic [NA-1:0]  pins_nxt;
  logic           out_valid_r;

  logic           accept;
  logic [1:0]     limits [NA];
  logic [PW-1:0]  phase_adv [NA];
  logic           period_done [NA];
  tspg_pkg::op_t  op;

  assign op       = tspg_pkg::op_t'(in_op);
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  assign limits[0] = in_limits_x;
  assign limits[1] = in_limits_y;
  assign limits[2] = in_limits_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      motor_en_r    <= tspg_pkg::MOTOR_ENABLE_RST;
      pulse_high_r  <= tspg_pkg::PULSE_HIGH_RST;
      step_period_r <= tspg_pkg::STEP_PERIOD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tspg_pkg::REG_MOTOR_ENABLE: motor_en_r    <= cfg_wdata[NA-1:0];
        tspg_pkg::REG_PULSE_HIGH:   pulse_high_r  <= cfg_wdata[PW-1:0];
        tspg_pkg::REG_STEP_PERIOD:  step_period_r <= cfg_wdata[PW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    free_run_nxt = free_run_r;
    pins_nxt     = pins_r;
    for (int a = 0; a < NA; a++) begin
      phase_nxt[a]   = phase_r[a];
      steps_nxt[a]   = steps_r[a];
      pos_nxt[a]     = pos_r[a];
      // phase saturates at the period
      phase_adv[a]   = ((free_run_r[a] || steps_r[a] != '0) && phase_r[a] < step_period_r)
                       ? phase_r[a] + 1'b1 : phase_r[a];
      period_done[a] = motor_en_r[a] && phase_adv[a] >= step_period_r;
    end
    unique case (op)
      tspg_pkg::OP_TICK: begin
        for (int a = 0; a < NA; a++) begin
          pins_nxt[a]  = phase_r[a] < pulse_high_r;
          phase_nxt[a] = period_done[a] ? '0 : phase_adv[a];
          if (period_done[a]) begin
            if (steps_r[a] != '0) begin
              steps_nxt[a] = steps_r[a] - 1'b1;
            end
            if (limits[a] == tspg_pkg::LIMITS_CLOSED) begin
              pos_nxt[a] = in_dir_bits[a] ? pos_r[a] - 1'b1 : pos_r[a] + 1'b1;
            end
          end
        end
      end
      tspg_pkg::OP_FREE_RUN: begin
        for (int a = 0; a < NA; a++) begin
          if (in_axis == 2'(a)) begin
            free_run_nxt[a] = in_run_enable;
          end
        end
      end
      tspg_pkg::OP_LOAD: begin
        for (int a = 0; a < NA; a++) begin
          if (in_axis == 2'(a)) begin
            free_run_nxt[a] = 1'b0;
            steps_nxt[a]    = in_step_count;
            phase_nxt[a]    = '0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_run_r  <= '1;
      pins_r      <= '0;
      out_valid_r <= 1'b0;
      for (int a = 0; a < NA; a++) begin
        phase_r[a] <= '0;
        steps_r[a] <= '0;
        pos_r[a]   <= '0;
      end
    end else begin
      if (accept) begin
        free_run_r <= free_run_nxt;
        pins_r     <= pins_nxt;
        for (int a = 0; a < NA; a++) begin
          phase_r[a] <= phase_nxt[a];
          steps_r[a] <= steps_nxt[a];
          pos_r[a]   <= pos_nxt[a];
        end
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // state registers hold the last result until the next accepted item
  assign out_valid     = out_valid_r;
  assign out_step_pins = pins_r;
  assign out_pos_x     = pos_r[0];
  assign out_pos_y     = pos_r[1];
  assign out_pos_z     = pos_r[2];

  always_comb begin
    for (int a = 0; a < NA; a++) begin
      out_busy_mask[a] = steps_r[a] != '0;
    end
  end

endmodule

// ===== design/tspg_chk.sv =====
// ----------------------------------------------------------------------------
// tspg_chk
// Port-level checks of the three-axis step pulse generator.
// ----------------------------------------------------------------------------
module tspg_chk (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  in_valid,
  input logic                                  in_ready,
  input logic [1:0]                            in_op,
  input logic                                  out_valid,
  input logic                                  out_ready,
  input logic [tspg_pkg::NUM_AXES-1:0]         out_step_pins,
  input logic signed [tspg_pkg::POS_WIDTH-1:0] out_pos_x,
  input logic signed [tspg_pkg::POS_WIDTH-1:0] out_pos_y,
  input logic signed [tspg_pkg::POS_WIDTH-1:0] out_pos_z,
  input logic [tspg_pkg::NUM_AXES-1:0]         out_busy_mask
);

  // a held result keeps its x position and step pins
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pos_x) && $stable(out_step_pins))
    else $error("result changed while stalled");

  // empty result side never blocks input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with no pending result");

  // every accepted item produces a result
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted item gave no result");

  // only tick items move the step pins
  a_pins_tick_only: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_op != tspg_pkg::OP_TICK |=> $stable(out_step_pins))
    else $error("step pins changed on a command item");

  // free-run command leaves positions and the busy mask alone
  a_free_run_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_op == tspg_pkg::OP_FREE_RUN |=>
      $stable(out_pos_x) && $stable(out_pos_y) && $stable(out_pos_z) &&
      $stable(out_busy_mask))
    else $error("free-run command changed counters");

endmodule

bind three_axis_step_pulse_generator tspg_chk u_tspg_chk (.*);

// ===== bench/tb_three_axis_step_pulse_generator.sv =====
// ----------------------------------------------------------------------------
// tb_three_axis_step_pulse_generator
// Self-checking bench for the three-axis step pulse generator. Items go in
// over the valid/ready input channel, a scoreboard class tracks phase, step
// count, free-run and position per axis, and every result is checked field by
// field. Directed items come first, then random phases with different
// register settings and different idle/stall pressure on both channels.
// ----------------------------------------------------------------------------
module tb_three_axis_step_pulse_generator;
  timeunit 1ns;
  timeprecision 1ps;

  import tspg_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [1:0] AXIS_X    = 2'd0;
  localparam logic [1:0] AXIS_Y    = 2'd1;
  localparam logic [1:0] AXIS_Z    = 2'd2;
  localparam logic [1:0] AXIS_NONE = 2'd3;
  localparam int ITEMS_PER_PHASE   = 155;
  localparam int CYCLE_LIMIT       = 600000;

  typedef struct packed {
    logic [1:0]                     op;
    logic [1:0]                     axis;
    logic                           run_enable;
    logic [COUNT_WIDTH-1:0]         step_count;
    logic [NUM_AXES-1:0][1:0]       limits;    // [0] x, [1] y, [2] z
    logic [NUM_AXES-1:0]            dir_bits;
  } motion_item_t;

  typedef struct packed {
    logic [NUM_AXES-1:0]                 step_pins;
    logic [NUM_AXES-1:0][POS_WIDTH-1:0]  pos;
    logic [NUM_AXES-1:0]                 busy;
  } axis_status_t;

  class motion_scoreboard;
    logic [NUM_AXES-1:0]    en_mask;
    logic [PHASE_WIDTH-1:0] pulse_high;
    logic [PHASE_WIDTH-1:0] period;
    logic [PHASE_WIDTH-1:0] phase [NUM_AXES];
    logic [COUNT_WIDTH-1:0] steps [NUM_AXES];
    bit                     free_run [NUM_AXES];
    logic [POS_WIDTH-1:0]   position [NUM_AXES];
    logic [NUM_AXES-1:0]    pins;
    axis_status_t           status_q [$];
    int                     mismatches;

    function new();
      en_mask    = MOTOR_ENABLE_RST;
      pulse_high = PULSE_HIGH_RST;
      period     = STEP_PERIOD_RST;
      for (int a = 0; a < NUM_AXES; a++) begin
        phase[a]    = '0;
        steps[a]    = '0;
        free_run[a] = 1'b1;
        position[a] = '0;
      end
      pins       = '0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [IDX_WIDTH-1:0] idx, logic [CFG_WIDTH-1:0] data);
      case (idx)
        REG_MOTOR_ENABLE: en_mask    = data[NUM_AXES-1:0];
        REG_PULSE_HIGH:   pulse_high = data;
        REG_STEP_PERIOD:  period     = data;
        default: ;
      endcase
    endfunction

    function void apply_tick(motion_item_t it);
      logic [NUM_AXES-1:0] new_pins;
      new_pins = '0;
      for (int a = 0; a < NUM_AXES; a++) begin
        if (phase[a] < pulse_high) new_pins[a] = 1'b1;
        // phase saturates at the period
        if ((free_run[a] || steps[a] != 0) && phase[a] < period) phase[a] = phase[a] + 1'b1;
        if (en_mask[a] && phase[a] >= period) begin
          if (steps[a] != 0) steps[a] = steps[a] - 1'b1;
          phase[a] = '0;
          if (it.limits[a] == LIMITS_CLOSED) begin
            position[a] = it.dir_bits[a] ? position[a] - 1'b1 : position[a] + 1'b1;
          end
        end
      end
      pins = new_pins;
    endfunction

    function void note_item(motion_item_t it);
      axis_status_t st;
      case (it.op)
        OP_TICK: apply_tick(it);
        OP_FREE_RUN: begin
          if (it.axis != AXIS_NONE) free_run[it.axis] = it.run_enable;
        end
        OP_LOAD: begin
          if (it.axis != AXIS_NONE) begin
            free_run[it.axis] = 1'b0;
            steps[it.axis]    = it.step_count;
            phase[it.axis]    = '0;
          end
        end
        default: ;
      endcase
      st.step_pins = pins;
      for (int a = 0; a < NUM_AXES; a++) begin
        st.pos[a]  = position[a];
        st.busy[a] = (steps[a] != 0);
      end
      status_q.push_back(st);
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= 10) $display("MISMATCH: %s", msg);
    endfunction

    function void compare_field(string name, logic [POS_WIDTH-1:0] want,
                                logic [POS_WIDTH-1:0] got);
      if (got !== want) report($sformatf("%s expected %h got %h", name, want, got));
    endfunction

    function void check_result(axis_status_t got);
      axis_status_t want;
      if (status_q.size() == 0) begin
        report("result with no item outstanding");
        return;
      end
      want = status_q.pop_front();
      compare_field("step_pins", POS_WIDTH'(want.step_pins), POS_WIDTH'(got.step_pins));
      compare_field("pos_x", want.pos[0], got.pos[0]);
      compare_field("pos_y", want.pos[1], got.pos[1]);
      compare_field("pos_z", want.pos[2], got.pos[2]);
      compare_field("busy_mask", POS_WIDTH'(want.busy), POS_WIDTH'(got.busy));
    endfunction

    function int pending();
      return status_q.size();
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          cfg_we = 1'b0;
  logic [IDX_WIDTH-1:0]          cfg_index = '0;
  logic [CFG_WIDTH-1:0]          cfg_wdata = '0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [1:0]                    in_op = '0;
  logic [1:0]                    in_axis = '0;
  logic                          in_run_enable = 1'b0;
  logic [COUNT_WIDTH-1:0]        in_step_count = '0;
  logic [1:0]                    in_limits_x = '0;
  logic [1:0]                    in_limits_y = '0;
  logic [1:0]                    in_limits_z = '0;
  logic [NUM_AXES-1:0]           in_dir_bits = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [NUM_AXES-1:0]           out_step_pins;
  logic signed [POS_WIDTH-1:0]   out_pos_x;
  logic signed [POS_WIDTH-1:0]   out_pos_y;
  logic signed [POS_WIDTH-1:0]   out_pos_z;
  logic [NUM_AXES-1:0]           out_busy_mask;

  motion_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int cycles = 0;

  three_axis_step_pulse_generator uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_op(in_op), .in_axis(in_axis), .in_run_enable(in_run_enable),
    .in_step_count(in_step_count),
    .in_limits_x(in_limits_x), .in_limits_y(in_limits_y), .in_limits_z(in_limits_z),
    .in_dir_bits(in_dir_bits),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_step_pins(out_step_pins),
    .out_pos_x(out_pos_x), .out_pos_y(out_pos_y), .out_pos_z(out_pos_z),
    .out_busy_mask(out_busy_mask)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("three_axis_step_pulse_generator test failed");
      $finish;
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    out_ready = ($urandom_range(99) >= recv_stall_pct);
  end

  // monitor: register writes, accepted items and accepted results
  always @(posedge clk) begin
    motion_item_t it;
    axis_status_t got;
    if (rst_n) begin
      if (cfg_we) sb.write_reg(cfg_index, cfg_wdata);
      if (in_valid && in_ready) begin
        it.op         = in_op;
        it.axis       = in_axis;
        it.run_enable = in_run_enable;
        it.step_count = in_step_count;
        it.limits     = {in_limits_z, in_limits_y, in_limits_x};
        it.dir_bits   = in_dir_bits;
        sb.note_item(it);
      end
      if (out_valid && out_ready) begin
        got.step_pins = out_step_pins;
        got.pos       = {out_pos_z, out_pos_y, out_pos_x};
        got.busy      = out_busy_mask;
        sb.check_result(got);
      end
    end
  end

  function automatic motion_item_t mk(logic [1:0] op, logic [1:0] axis, logic run,
                                      logic [COUNT_WIDTH-1:0] count, logic [1:0] lx,
                                      logic [1:0] ly, logic [1:0] lz,
                                      logic [NUM_AXES-1:0] dir);
    motion_item_t it;
    it.op         = op;
    it.axis       = axis;
    it.run_enable = run;
    it.step_count = count;
    it.limits     = {lz, ly, lx};
    it.dir_bits   = dir;
    return it;
  endfunction

  function automatic logic [1:0] pick_limits();
    return ($urandom_range(3) != 0) ? LIMITS_CLOSED : 2'($urandom_range(3));
  endfunction

  function automatic logic [COUNT_WIDTH-1:0] pick_count();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3:    return COUNT_WIDTH'($urandom_range(65535));
      default: return COUNT_WIDTH'($urandom_range(1, 12));
    endcase
  endfunction

  function automatic motion_item_t random_item();
    int r;
    logic [1:0] op;
    r = $urandom_range(99);
    if (r < 70) op = OP_TICK;
    else if (r < 82) op = OP_FREE_RUN;
    else if (r < 94) op = OP_LOAD;
    else op = OP_UNUSED;
    return mk(op, 2'($urandom_range(3)), 1'($urandom_range(1)), pick_count(),
              pick_limits(), pick_limits(), pick_limits(), 3'($urandom_range(7)));
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(motion_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid      = 1'b1;
    in_op         = it.op;
    in_axis       = it.axis;
    in_run_enable = it.run_enable;
    in_step_count = it.step_count;
    in_limits_x   = it.limits[0];
    in_limits_y   = it.limits[1];
    in_limits_z   = it.limits[2];
    in_dir_bits   = it.dir_bits;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [IDX_WIDTH-1:0] idx, logic [CFG_WIDTH-1:0] data);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // block must be idle before registers change
  task automatic drain();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic run_phase(logic [NUM_AXES-1:0] en, logic [7:0] pulse, logic [7:0] per,
                           int send_idle, int recv_stall);
    drain();
    write_reg(REG_MOTOR_ENABLE, CFG_WIDTH'(en));
    write_reg(REG_PULSE_HIGH, pulse);
    write_reg(REG_STEP_PERIOD, per);
    send_idle_pct  = send_idle;
    recv_stall_pct = recv_stall;
    repeat (ITEMS_PER_PHASE) send_item(random_item());
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // reset settings: motors disabled, so no period ever completes
    send_item(mk(OP_TICK, AXIS_X, 1'b0, '0, 2'd3, 2'd3, 2'd3, 3'b000));
    send_item(mk(OP_UNUSED, AXIS_NONE, 1'b1, '1, 2'd3, 2'd3, 2'd3, 3'b111));
    send_item(mk(OP_FREE_RUN, AXIS_NONE, 1'b0, '0, 2'd0, 2'd0, 2'd0, 3'b000));
    drain();
    write_reg(REG_MOTOR_ENABLE, 8'd7);
    write_reg(REG_PULSE_HIGH, 8'd1);
    write_reg(REG_STEP_PERIOD, 8'd2);
    // x and z count down through zero
    repeat (4) send_item(mk(OP_TICK, AXIS_X, 1'b0, '0, 2'd3, 2'd3, 2'd3, 3'b101));
    send_item(mk(OP_TICK, AXIS_Y, 1'b1, '1, 2'd1, 2'd2, 2'd0, 3'b111));
    send_item(mk(OP_LOAD, AXIS_X, 1'b0, '0, 2'd3, 2'd3, 2'd3, 3'b000));
    send_item(mk(OP_LOAD, AXIS_Y, 1'b0, '1, 2'd3, 2'd3, 2'd3, 3'b000));
    send_item(mk(OP_LOAD, AXIS_Z, 1'b0, 16'd3, 2'd3, 2'd3, 2'd3, 3'b000));
    send_item(mk(OP_LOAD, AXIS_NONE, 1'b1, 16'd5, 2'd3, 2'd3, 2'd3, 3'b000));
    repeat (4) send_item(mk(OP_TICK, AXIS_Z, 1'b0, '0, 2'd3, 2'd3, 2'd3, 3'b010));
    send_item(mk(OP_FREE_RUN, AXIS_X, 1'b1, '0, 2'd3, 2'd3, 2'd3, 3'b000));
    send_item(mk(OP_FREE_RUN, AXIS_Z, 1'b0, '0, 2'd3, 2'd3, 2'd3, 3'b000));
    repeat (2) send_item(mk(OP_TICK, AXIS_X, 1'b0, '0, 2'd3, 2'd3, 2'd3, 3'b000));
    drain();
    write_reg(REG_PULSE_HIGH, 8'd255);
    write_reg(REG_STEP_PERIOD, 8'd255);
    repeat (4) send_item(mk(OP_TICK, AXIS_X, 1'b0, '0, 2'd3, 2'd3, 2'd3, 3'b001));
    // period now below the phase reached above
    drain();
    write_reg(REG_PULSE_HIGH, 8'd0);
    write_reg(REG_STEP_PERIOD, 8'd2);
    send_item(mk(OP_TICK, AXIS_X, 1'b0, '0, 2'd3, 2'd3, 2'd3, 3'b110));
    drain();
    write_reg(REG_STEP_PERIOD, 8'd0);
    repeat (2) send_item(mk(OP_TICK, AXIS_X, 1'b0, '0, 2'd3, 2'd3, 2'd3, 3'b011));

    run_phase(3'b111, 8'd2,   8'd4,   0,  0);
    run_phase(3'b111, 8'd0,   8'd1,   88, 0);
    run_phase(3'b101, 8'd255, 8'd255, 0,  88);
    run_phase(3'b011, 8'd3,   8'd0,   32, 32);
    run_phase(3'b110, 8'd7,   8'd7,   0,  0);
    run_phase(3'b111, 8'd1,   8'd2,   88, 0);
    run_phase(3'b000, 8'd5,   8'd10,  0,  88);
    run_phase(3'b111, 8'd128, 8'd3,   32, 32);
    run_phase(3'b111, 8'd9,   8'd5,   0,  0);

    drain();
    repeat (20) @(negedge clk);
    if (sb.mismatches == 0) begin
      $display("three_axis_step_pulse_generator test passed");
    end else begin
      $display("three_axis_step_pulse_generator test failed");
    end
    $finish;
  end

endmodule
